// ===== rtl/lrudp_pkg.sv =====
package lrudp_pkg;

  // Fixed field widths of the stream payloads
  localparam int MODE_W  = 2;
  localparam int PID_W   = 4;
  localparam int SIZE_W  = 8;
  localparam int PAGE_W  = 6;
  localparam int STAT_W  = 3;
  localparam int FIDX_W  = 4;
  localparam int EPID_W  = 4;
  localparam int EPAGE_W = 6;
  localparam int ESLOT_W = 6;
  localparam int FREE_W  = 5;
  localparam int LIMIT_W = 8;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 32;

  localparam logic [LIMIT_W-1:0] SIZE_LIMIT_RST = 8'd100;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_CALL = 2'd1,
    MODE_DEL  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_LOADED    = 3'd1,
    ST_EVICTED   = 3'd2,
    ST_NO_PROC   = 3'd3,
    ST_NO_PAGE   = 3'd4,
    ST_EXISTS    = 3'd5,
    ST_SWAP_FULL = 3'd6,
    ST_BAD_SIZE  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    LOC_NONE = 2'd0,
    LOC_RAM  = 2'd1,
    LOC_SWAP = 2'd2
  } loc_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_PAGES,
    OP_ADD_PLACE,
    OP_ADD_EVICT,
    OP_ADD_SWAP,
    OP_ADD_FIN,
    OP_RD_CALL,
    OP_RD_DEL,
    OP_HIT,
    OP_CALL_FREE,
    OP_CALL_EVICT,
    OP_CALL_PLACE,
    OP_DEL_REL,
    OP_DEL_FIN,
    OP_OUT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_SIZE,
    S_ADD_LOOP,
    S_ADD_FIN,
    S_CALL_WAIT,
    S_CALL_PLACE,
    S_DEL_RD,
    S_DEL_REL,
    S_DEL_FIN,
    S_FINISH
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e  op;
    logic    st_we;
    status_e st;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  bad_pid;
    logic  present;
    logic  bad_page;
    logic  bad_size;
    logic  swap_short;
    logic  frame_avail;
    logic  evicted;
    logic  add_last;
    logic  del_last;
    logic  rd_ram;
    logic  out_busy;
  } dp_stat_t;

endpackage

// ===== rtl/lru_demand_paging_manager.sv =====
// LRU demand paging manager. Each input transfer is one command: add a process
// (mode 0), call one of its pages (mode 1) or delete it (mode 2); each command
// gives exactly one result transfer. Pages are PAGE_UNITS units and live in one
// of FRAMES RAM frames or SWAP_SLOTS swap slots; eviction always takes the
// least recently used frame, tracked as an exact recency rank per frame.
// One command is worked at a time, one frame or slot operation per cycle,
// with the page table in a single-port memory (registered read). An add puts
// each of its pages in a frame or a swap slot in turn, with at most one eviction;
// a delete reads and releases each page of the process in turn. The result sits
// in an output register; the next command is accepted while it waits, and the
// block holds before its own result until that one is taken. No clearing pass
// after reset: page table entries are only read after an add has written them.
// The user writes size_limit through cfg_we_i/cfg_wdata_i only while idle; the
// block itself does not enforce it.
module lru_demand_paging_manager
  import lrudp_pkg::*;
#(
  parameter int FRAMES        = 16,
  parameter int SWAP_SLOTS    = 64,
  parameter int MAX_PAGES     = 32,
  parameter int MAX_PROCESSES = 16,
  parameter int PAGE_UNITS    = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // process_id[3:0], size_units[11:4], page_number[17:12], zero fill
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // mode[1:0]
  input  logic [MODE_W-1:0]    s_axis_tuser,
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status[2:0], frame_index[6:3], evicted[7], evicted_process[11:8],
  // evicted_page[17:12], evicted_slot[23:18], free_frames[28:24], zero fill
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // size_limit register
  input  logic                 cfg_we_i,
  input  logic [LIMIT_W-1:0]   cfg_wdata_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lrudp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  lrudp_datapath #(
    .FRAMES        (FRAMES),
    .SWAP_SLOTS    (SWAP_SLOTS),
    .MAX_PAGES     (MAX_PAGES),
    .MAX_PROCESSES (MAX_PROCESSES),
    .PAGE_UNITS    (PAGE_UNITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_data_o    (m_axis_tdata),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ===== rtl/lrudp_ctrl.sv =====
module lrudp_ctrl
  import lrudp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '{op: OP_NOP, st_we: 1'b0, st: ST_DONE};
    s_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.mode == MODE_NONE) begin
          state_d = S_FINISH;
        end else if (stat_i.bad_pid) begin
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_NO_PROC;
          state_d     = S_FINISH;
        end else begin
          case (stat_i.mode)
            MODE_ADD: begin
              if (stat_i.present) begin
                cmd_o.st_we = 1'b1;
                cmd_o.st    = ST_EXISTS;
                state_d     = S_FINISH;
              end else begin
                cmd_o.op = OP_PAGES;
                state_d  = S_ADD_SIZE;
              end
            end
            MODE_CALL: begin
              if (!stat_i.present) begin
                cmd_o.st_we = 1'b1;
                cmd_o.st    = ST_NO_PROC;
                state_d     = S_FINISH;
              end else if (stat_i.bad_page) begin
                cmd_o.st_we = 1'b1;
                cmd_o.st    = ST_NO_PAGE;
                state_d     = S_FINISH;
              end else begin
                cmd_o.op = OP_RD_CALL;
                state_d  = S_CALL_WAIT;
              end
            end
            MODE_DEL: begin
              if (!stat_i.present) begin
                cmd_o.st_we = 1'b1;
                cmd_o.st    = ST_NO_PROC;
                state_d     = S_FINISH;
              end else begin
                state_d = S_DEL_RD;
              end
            end
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_ADD_SIZE: begin
        if (stat_i.bad_size) begin
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_BAD_SIZE;
          state_d     = S_FINISH;
        end else if (stat_i.swap_short) begin
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_SWAP_FULL;
          state_d     = S_FINISH;
        end else begin
          state_d = S_ADD_LOOP;
        end
      end
      S_ADD_LOOP: begin
        if (stat_i.frame_avail) begin
          cmd_o.op = OP_ADD_PLACE;
          if (stat_i.add_last) state_d = S_ADD_FIN;
        end else if (!stat_i.evicted) begin
          // frees exactly one frame, filled on the next pass
          cmd_o.op = OP_ADD_EVICT;
        end else begin
          cmd_o.op = OP_ADD_SWAP;
          if (stat_i.add_last) state_d = S_ADD_FIN;
        end
      end
      S_ADD_FIN: begin
        cmd_o.op = OP_ADD_FIN;
        state_d  = S_FINISH;
      end
      S_CALL_WAIT: begin
        if (stat_i.rd_ram) begin
          cmd_o.op = OP_HIT;
          state_d  = S_FINISH;
        end else if (stat_i.frame_avail) begin
          cmd_o.op    = OP_CALL_FREE;
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_LOADED;
          state_d     = S_FINISH;
        end else begin
          cmd_o.op    = OP_CALL_EVICT;
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_EVICTED;
          state_d     = S_CALL_PLACE;
        end
      end
      S_CALL_PLACE: begin
        cmd_o.op = OP_CALL_PLACE;
        state_d  = S_FINISH;
      end
      S_DEL_RD: begin
        cmd_o.op = OP_RD_DEL;
        state_d  = S_DEL_REL;
      end
      S_DEL_REL: begin
        cmd_o.op = OP_DEL_REL;
        state_d  = stat_i.del_last ? S_DEL_FIN : S_DEL_RD;
      end
      S_DEL_FIN: begin
        cmd_o.op = OP_DEL_FIN;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/lrudp_datapath.sv =====
module lrudp_datapath
  import lrudp_pkg::*;
#(
  parameter int FRAMES        = 16,
  parameter int SWAP_SLOTS    = 64,
  parameter int MAX_PAGES     = 32,
  parameter int MAX_PROCESSES = 16,
  parameter int PAGE_UNITS    = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [S_TDATA_W-1:0] s_data_i,
  input  logic [MODE_W-1:0]    s_user_i,
  input  logic                 cfg_we_i,
  input  logic [LIMIT_W-1:0]   cfg_wdata_i,
  output logic [M_TDATA_W-1:0] m_data_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o
);

  localparam int FW   = $clog2(FRAMES);
  localparam int FCW  = $clog2(FRAMES + 1);
  localparam int SW   = $clog2(SWAP_SLOTS);
  localparam int SCW  = $clog2(SWAP_SLOTS + 1);
  localparam int PGW  = $clog2(MAX_PAGES);
  localparam int PPW  = $clog2(MAX_PAGES + 1);
  localparam int PIW  = $clog2(MAX_PROCESSES);
  localparam int WW   = (FW > SW) ? FW : SW;
  localparam int AW   = PIW + PGW;
  localparam int PT_DEPTH = MAX_PROCESSES << PGW;
  // ceil(size / PAGE_UNITS) as a reciprocal multiply, exact for 9-bit numerators
  localparam int RSH   = 20;
  localparam int RECIP = ((1 << RSH) + PAGE_UNITS - 1) / PAGE_UNITS;
  localparam int NUM_W = SIZE_W + 1;
  localparam int RW    = RSH + 1;
  localparam int PGS_W = SIZE_W + 1;

  // input item
  mode_e             mode_q;
  logic [PID_W-1:0]  pid_q;
  logic [SIZE_W-1:0] size_q;
  logic [PAGE_W-1:0] page_q;
  logic [PGS_W-1:0]  pages_q;
  logic [LIMIT_W-1:0] limit_q;

  // frames, slots, processes
  logic [FRAMES-1:0]     own_v_q;
  logic [PIW-1:0]        own_pid_q  [FRAMES];
  logic [PPW-1:0]        own_page_q [FRAMES];
  logic [FW-1:0]         rec_q      [FRAMES];
  logic [SWAP_SLOTS-1:0] slot_used_q;
  logic [PPW-1:0]        pp_q       [MAX_PROCESSES];
  logic [FCW-1:0]        free_cnt_q;
  logic [SCW-1:0]        slot_cnt_q;

  // sequencing
  logic [PPW-1:0] cnt_q;
  logic           evicted_q;
  logic           first_ram_q;
  logic [FW-1:0]  first_frame_q;

  // page table
  logic [WW+1:0] pt_mem [PT_DEPTH];
  logic [WW+1:0] pt_rd_q;
  logic          pt_we;
  logic [AW-1:0] pt_waddr;
  logic [WW+1:0] pt_wdata;
  logic          pt_re;
  logic [AW-1:0] pt_raddr;

  // result
  status_e        res_status_q;
  logic [FW-1:0]  res_frame_q;
  logic           res_ev_q;
  logic [PIW-1:0] res_ev_pid_q;
  logic [PPW-1:0] res_ev_page_q;
  logic [SW-1:0]  res_ev_slot_q;
  logic [M_TDATA_W-1:0] m_data_q;
  logic                 m_valid_q;

  // derived
  logic [PIW-1:0]       pid_ix;
  logic [PPW-1:0]       pp_cur;
  logic [FW-1:0]        ffi;
  logic [SW-1:0]        ffs;
  logic [FW-1:0]        vic;
  logic [FW-1:0]        lru_tgt;
  logic                 slot_avail;
  loc_e                 rd_kind;
  logic [FW-1:0]        rd_frame;
  logic [SW-1:0]        rd_slot;
  logic [SW-1:0]        ev_slot;
  logic [PPW-1:0]       pl_page;
  logic [NUM_W-1:0]     pg_num;
  logic [NUM_W+RW-1:0]  pg_prod;
  int                   rest;

  assign pid_ix     = PIW'(pid_q);
  assign pp_cur     = pp_q[pid_ix];
  assign slot_avail = (slot_cnt_q != '0);
  assign lru_tgt    = FW'(FRAMES - 1 - int'(free_cnt_q));
  assign rd_kind    = loc_e'(pt_rd_q[WW+1:WW]);
  assign rd_frame   = FW'(pt_rd_q[WW-1:0]);
  assign rd_slot    = SW'(pt_rd_q[WW-1:0]);
  assign pl_page    = (cmd_i.op == OP_ADD_PLACE) ? PPW'(cnt_q + 1'b1) : PPW'(page_q);
  assign ev_slot    = (cmd_i.op == OP_CALL_EVICT && !slot_avail) ? rd_slot : ffs;
  assign pg_num     = NUM_W'(size_q) + NUM_W'(PAGE_UNITS - 1);
  assign pg_prod    = pg_num * RW'(RECIP);
  assign rest       = (int'(pages_q) > int'(free_cnt_q)) ?
                      (int'(pages_q) - int'(free_cnt_q)) : 0;

  // lowest free frame, lowest free slot, LRU frame
  always_comb begin
    ffi = '0;
    for (int f = FRAMES - 1; f >= 0; f--) begin
      if (!own_v_q[f]) ffi = FW'(f);
    end
  end

  always_comb begin
    ffs = '0;
    for (int s = SWAP_SLOTS - 1; s >= 0; s--) begin
      if (!slot_used_q[s]) ffs = SW'(s);
    end
  end

  always_comb begin
    vic = '0;
    for (int f = 0; f < FRAMES; f++) begin
      if (own_v_q[f] && rec_q[f] == lru_tgt) vic = FW'(f);
    end
  end

  always_comb begin
    stat_o.mode        = mode_q;
    stat_o.bad_pid     = (pid_q == '0) || (int'(pid_q) >= MAX_PROCESSES);
    stat_o.present     = (pp_cur != '0);
    stat_o.bad_page    = (page_q == '0) || (int'(page_q) > int'(pp_cur));
    stat_o.bad_size    = (size_q == '0) || (size_q > limit_q) || (int'(pages_q) > MAX_PAGES);
    stat_o.swap_short  = (rest > int'(slot_cnt_q));
    stat_o.frame_avail = (free_cnt_q != '0);
    stat_o.evicted     = evicted_q;
    stat_o.add_last    = (int'(cnt_q) + 1 == int'(pages_q));
    stat_o.del_last    = (int'(cnt_q) + 1 == int'(pp_cur));
    stat_o.rd_ram      = (rd_kind == LOC_RAM);
    stat_o.out_busy    = m_valid_q && !m_ready_i;
  end

  // page table port selection
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = '0;
    pt_wdata = '0;
    pt_re    = 1'b0;
    pt_raddr = '0;
    case (cmd_i.op)
      OP_ADD_PLACE: begin
        pt_we    = 1'b1;
        pt_waddr = {pid_ix, PGW'(cnt_q)};
        pt_wdata = {LOC_RAM, WW'(ffi)};
      end
      OP_CALL_FREE, OP_CALL_PLACE: begin
        pt_we    = 1'b1;
        pt_waddr = {pid_ix, PGW'(page_q - 1'b1)};
        pt_wdata = {LOC_RAM, WW'(ffi)};
      end
      OP_ADD_EVICT, OP_CALL_EVICT: begin
        pt_we    = 1'b1;
        pt_waddr = {own_pid_q[vic], PGW'(own_page_q[vic] - 1'b1)};
        pt_wdata = {LOC_SWAP, WW'(ev_slot)};
      end
      OP_ADD_SWAP: begin
        pt_we    = 1'b1;
        pt_waddr = {pid_ix, PGW'(cnt_q)};
        pt_wdata = {LOC_SWAP, WW'(ffs)};
      end
      OP_RD_CALL: begin
        pt_re    = 1'b1;
        pt_raddr = {pid_ix, PGW'(page_q - 1'b1)};
      end
      OP_RD_DEL: begin
        pt_re    = 1'b1;
        pt_raddr = {pid_ix, PGW'(cnt_q)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    if (pt_re) pt_rd_q <= pt_mem[pt_raddr];
  end

  // control state: occupancy, recency, counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_v_q     <= '0;
      slot_used_q <= '0;
      for (int f = 0; f < FRAMES; f++) rec_q[f] <= '0;
      for (int p = 0; p < MAX_PROCESSES; p++) pp_q[p] <= '0;
      free_cnt_q  <= FCW'(FRAMES);
      slot_cnt_q  <= SCW'(SWAP_SLOTS);
      cnt_q       <= '0;
      evicted_q   <= 1'b0;
      first_ram_q <= 1'b0;
      m_valid_q   <= 1'b0;
      limit_q     <= SIZE_LIMIT_RST;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (m_ready_i) m_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_LOAD: begin
          cnt_q       <= '0;
          evicted_q   <= 1'b0;
          first_ram_q <= 1'b0;
        end
        OP_ADD_PLACE, OP_CALL_FREE, OP_CALL_PLACE: begin
          for (int g = 0; g < FRAMES; g++) begin
            if (own_v_q[g] && FW'(g) != ffi) rec_q[g] <= rec_q[g] + 1'b1;
          end
          rec_q[ffi]   <= '0;
          own_v_q[ffi] <= 1'b1;
          free_cnt_q   <= free_cnt_q - 1'b1;
          if (cmd_i.op == OP_ADD_PLACE) begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == '0) first_ram_q <= 1'b1;
          end
          if (cmd_i.op == OP_CALL_FREE) begin
            slot_used_q[rd_slot] <= 1'b0;
            slot_cnt_q           <= slot_cnt_q + 1'b1;
          end
        end
        OP_ADD_EVICT, OP_CALL_EVICT: begin
          // called page leaves its slot first; a full swap reuses that slot
          if (cmd_i.op == OP_CALL_EVICT) slot_used_q[rd_slot] <= 1'b0;
          slot_used_q[ev_slot] <= 1'b1;
          if (cmd_i.op == OP_ADD_EVICT) begin
            slot_cnt_q <= slot_cnt_q - 1'b1;
            if (own_pid_q[vic] == pid_ix && own_page_q[vic] == PPW'(1)) first_ram_q <= 1'b0;
          end
          for (int g = 0; g < FRAMES; g++) begin
            if (own_v_q[g] && rec_q[g] > rec_q[vic]) rec_q[g] <= rec_q[g] - 1'b1;
          end
          rec_q[vic]   <= '0;
          own_v_q[vic] <= 1'b0;
          free_cnt_q   <= free_cnt_q + 1'b1;
          evicted_q    <= 1'b1;
        end
        OP_ADD_SWAP: begin
          slot_used_q[ffs] <= 1'b1;
          slot_cnt_q       <= slot_cnt_q - 1'b1;
          cnt_q            <= cnt_q + 1'b1;
        end
        OP_ADD_FIN: pp_q[pid_ix] <= PPW'(pages_q);
        OP_HIT: begin
          for (int g = 0; g < FRAMES; g++) begin
            if (own_v_q[g] && FW'(g) != rd_frame && rec_q[g] < rec_q[rd_frame]) begin
              rec_q[g] <= rec_q[g] + 1'b1;
            end
          end
          rec_q[rd_frame] <= '0;
        end
        OP_DEL_REL: begin
          cnt_q <= cnt_q + 1'b1;
          case (rd_kind)
            LOC_RAM: begin
              for (int g = 0; g < FRAMES; g++) begin
                if (own_v_q[g] && rec_q[g] > rec_q[rd_frame]) rec_q[g] <= rec_q[g] - 1'b1;
              end
              rec_q[rd_frame]   <= '0;
              own_v_q[rd_frame] <= 1'b0;
              free_cnt_q        <= free_cnt_q + 1'b1;
            end
            LOC_SWAP: begin
              slot_used_q[rd_slot] <= 1'b0;
              slot_cnt_q           <= slot_cnt_q + 1'b1;
            end
            default: ;
          endcase
        end
        OP_DEL_FIN: pp_q[pid_ix] <= '0;
        OP_OUT:     m_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        mode_q        <= mode_e'(s_user_i);
        pid_q         <= s_data_i[PID_W-1:0];
        size_q        <= s_data_i[PID_W +: SIZE_W];
        page_q        <= s_data_i[PID_W+SIZE_W +: PAGE_W];
        res_frame_q   <= '0;
        res_ev_q      <= 1'b0;
        res_ev_pid_q  <= '0;
        res_ev_page_q <= '0;
        res_ev_slot_q <= '0;
      end
      OP_PAGES: pages_q <= PGS_W'(pg_prod >> RSH);
      OP_ADD_PLACE, OP_CALL_FREE, OP_CALL_PLACE: begin
        own_pid_q[ffi]  <= pid_ix;
        own_page_q[ffi] <= pl_page;
        if (cmd_i.op == OP_ADD_PLACE && cnt_q == '0) first_frame_q <= ffi;
        if (cmd_i.op != OP_ADD_PLACE) res_frame_q <= ffi;
      end
      OP_ADD_EVICT, OP_CALL_EVICT: begin
        res_ev_q      <= 1'b1;
        res_ev_pid_q  <= own_pid_q[vic];
        res_ev_page_q <= own_page_q[vic];
        res_ev_slot_q <= ev_slot;
      end
      OP_ADD_FIN: res_frame_q <= first_ram_q ? first_frame_q : '0;
      OP_HIT:     res_frame_q <= rd_frame;
      OP_OUT: begin
        m_data_q <= {3'b000, FREE_W'(free_cnt_q), ESLOT_W'(res_ev_slot_q),
                     EPAGE_W'(res_ev_page_q), EPID_W'(res_ev_pid_q), res_ev_q,
                     FIDX_W'(res_frame_q), res_status_q};
      end
      default: ;
    endcase
    if (cmd_i.op == OP_LOAD) begin
      res_status_q <= ST_DONE;
    end else if (cmd_i.st_we) begin
      res_status_q <= cmd_i.st;
    end
  end

  assign m_data_o  = m_data_q;
  assign m_valid_o = m_valid_q;

endmodule

// ===== tb/tb_lru_demand_paging_manager.sv =====
`timescale 1ns / 1ps

module tb_lru_demand_paging_manager;
  import lrudp_pkg::*;

  localparam int NFRAMES = 16;
  localparam int NSLOTS  = 16 * 4;
  localparam int NPAGES  = 32;
  localparam int NPROCS  = 16;
  localparam int UNITS   = 4;

  typedef struct packed {
    status_e         st;
    logic [3:0]      frame;
    logic            ev;
    logic [3:0]      ev_pid;
    logic [5:0]      ev_page;
    logic [5:0]      ev_slot;
    logic [4:0]      free_cnt;
  } result_t;

  // paging state mirror: loc kind + where per (pid, page)
  class paging_scoreboard;
    loc_e        pt_kind [NPROCS*NPAGES];
    int          pt_where[NPROCS*NPAGES];
    int          own_pid [NFRAMES];
    int          own_page[NFRAMES];
    int          rank    [NFRAMES];
    bit          slot_busy[NSLOTS];
    int          npages  [NPROCS];
    int          limit;
    result_t     pending[$];
    int          errors;

    function void clear();
      foreach (pt_kind[i]) begin pt_kind[i] = LOC_NONE; pt_where[i] = 0; end
      foreach (own_pid[i]) begin own_pid[i] = 0; own_page[i] = 0; rank[i] = 0; end
      foreach (slot_busy[i]) slot_busy[i] = 0;
      foreach (npages[i]) npages[i] = 0;
      limit = SIZE_LIMIT_RST;
      errors = 0;
    endfunction

    function int free_frames();
      int n;
      n = 0;
      foreach (own_pid[f]) if (own_pid[f] == 0) n++;
      return n;
    endfunction

    function int free_slots();
      int n;
      n = 0;
      foreach (slot_busy[s]) if (!slot_busy[s]) n++;
      return n;
    endfunction

    function int first_frame();
      foreach (own_pid[f]) if (own_pid[f] == 0) return f;
      return -1;
    endfunction

    function int first_slot();
      foreach (slot_busy[s]) if (!slot_busy[s]) return s;
      return -1;
    endfunction

    function void place(int f, int pid, int pg);
      own_pid[f] = pid; own_page[f] = pg;
      pt_kind[pid*NPAGES+pg-1] = LOC_RAM; pt_where[pid*NPAGES+pg-1] = f;
      foreach (own_pid[g])
        if (g != f && own_pid[g] != 0 && rank[g] < 255) rank[g]++;
      rank[f] = 0;
    endfunction

    function void release_frame(int f);
      int old;
      old = rank[f];
      own_pid[f] = 0; own_page[f] = 0; rank[f] = 0;
      foreach (own_pid[g]) if (own_pid[g] != 0 && rank[g] > old) rank[g]--;
    endfunction

    // LRU frame goes to swap slot s; returns the freed frame
    function int evict_to(int s, ref result_t r);
      int v, best, pid, pg;
      v = 0; best = -1;
      foreach (own_pid[f])
        if (own_pid[f] != 0 && rank[f] > best) begin best = rank[f]; v = f; end
      pid = own_pid[v]; pg = own_page[v];
      pt_kind[pid*NPAGES+pg-1] = LOC_SWAP; pt_where[pid*NPAGES+pg-1] = s;
      slot_busy[s] = 1;
      release_frame(v);
      r.ev = 1; r.ev_pid = 4'(pid); r.ev_page = 6'(pg); r.ev_slot = 6'(s);
      return v;
    endfunction

    function status_e add_proc(int pid, int sz, ref result_t r);
      int pages, rest, pg, s, v;
      if (npages[pid] != 0) return ST_EXISTS;
      if (sz == 0 || sz > limit) return ST_BAD_SIZE;
      pages = (sz + UNITS - 1) / UNITS;
      if (pages > NPAGES) return ST_BAD_SIZE;
      rest = pages > free_frames() ? pages - free_frames() : 0;
      if (rest > free_slots()) return ST_SWAP_FULL;
      pg = 1;
      while (pg <= pages && first_frame() >= 0) begin
        place(first_frame(), pid, pg);
        pg++;
      end
      if (pg <= pages) begin
        s = first_slot();
        v = evict_to(s, r);
        place(v, pid, pg);
        pg++;
        while (pg <= pages) begin
          s = first_slot();
          slot_busy[s] = 1;
          pt_kind[pid*NPAGES+pg-1] = LOC_SWAP; pt_where[pid*NPAGES+pg-1] = s;
          pg++;
        end
      end
      npages[pid] = pages;
      if (pt_kind[pid*NPAGES] == LOC_RAM) r.frame = 4'(pt_where[pid*NPAGES]);
      return ST_DONE;
    endfunction

    function status_e call_page(int pid, int pg, ref result_t r);
      int idx, f, s, own, old;
      status_e st;
      if (npages[pid] == 0) return ST_NO_PROC;
      if (pg == 0 || pg > npages[pid]) return ST_NO_PAGE;
      idx = pid*NPAGES + pg - 1;
      if (pt_kind[idx] == LOC_RAM) begin
        f = pt_where[idx];
        old = rank[f];
        foreach (own_pid[g]) if (g != f && own_pid[g] != 0 && rank[g] < old) rank[g]++;
        rank[f] = 0;
        r.frame = 4'(f);
        return ST_DONE;
      end
      own = pt_where[idx];
      f = first_frame();
      st = ST_LOADED;
      if (f < 0) begin
        s = first_slot();
        slot_busy[own] = 0;
        if (s < 0) s = own;
        f = evict_to(s, r);
        st = ST_EVICTED;
      end else slot_busy[own] = 0;
      place(f, pid, pg);
      r.frame = 4'(f);
      return st;
    endfunction

    function status_e delete_proc(int pid);
      int idx;
      if (npages[pid] == 0) return ST_NO_PROC;
      for (int p = 0; p < NPAGES; p++) begin
        idx = pid*NPAGES + p;
        if (pt_kind[idx] == LOC_RAM) release_frame(pt_where[idx]);
        else if (pt_kind[idx] == LOC_SWAP) slot_busy[pt_where[idx]] = 0;
        pt_kind[idx] = LOC_NONE; pt_where[idx] = 0;
      end
      npages[pid] = 0;
      return ST_DONE;
    endfunction

    // note an accepted command and queue its expected result
    function void note_command(mode_e m, int pid, int sz, int pg);
      result_t r;
      status_e st;
      r = '0;
      st = ST_DONE;
      if (m != MODE_NONE) begin
        if (pid == 0 || pid >= NPROCS) st = ST_NO_PROC;
        else if (m == MODE_ADD) st = add_proc(pid, sz, r);
        else if (m == MODE_CALL) st = call_page(pid, pg, r);
        else st = delete_proc(pid);
      end
      if (st >= ST_NO_PROC) r.frame = 0;
      r.st = st;
      r.free_cnt = 5'(free_frames());
      pending.insert(pending.size(), r);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(logic [M_TDATA_W-1:0] d);
      result_t w;
      if (pending.size() == 0) begin
        report("unexpected transfer", d, 0);
        return;
      end
      w = pending.pop_front();
      if (d[2:0]   != w.st)       report("status", d[2:0], w.st);
      if (d[6:3]   != w.frame)    report("frame_index", d[6:3], w.frame);
      if (d[7]     != w.ev)       report("evicted", d[7], w.ev);
      if (d[11:8]  != w.ev_pid)   report("evicted_process", d[11:8], w.ev_pid);
      if (d[17:12] != w.ev_page)  report("evicted_page", d[17:12], w.ev_page);
      if (d[23:18] != w.ev_slot)  report("evicted_slot", d[23:18], w.ev_slot);
      if (d[28:24] != w.free_cnt) report("free_frames", d[28:24], w.free_cnt);
      if (d[31:29] != 0)          report("fill bits", d[31:29], 0);
    endtask
  endclass

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 s_axis_tvalid = 0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [MODE_W-1:0]    s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_we_i = 0;
  logic [LIMIT_W-1:0]   cfg_wdata_i = '0;

  paging_scoreboard sb;
  bit stall_on = 1;   // receiver stall pattern enable

  always #5 clk_i = ~clk_i;

  lru_demand_paging_manager u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // result side: check at rising edge, stall pattern updated at falling edge
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 23;
    if (!stall_on) m_axis_tready <= 1;
    else if (stall_phase < 7) m_axis_tready <= (stall_phase % 3 == 0);
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  int burst_left = 0;

  // one command transfer; bursts with random gaps in between
  task send_cmd(mode_e m, int pid, int sz, int pg);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= {6'b0, pg[5:0], sz[7:0], pid[3:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_command(m, pid, sz, pg);
    @(negedge clk_i);
  endtask

  task drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task write_limit(int v);
    drain();
    cfg_we_i    <= 1;
    cfg_wdata_i <= 8'(v);
    @(negedge clk_i);
    cfg_we_i    <= 0;
    sb.limit = v;
  endtask

  // mostly well-formed traffic over the valid pids so adds, calls, evictions land
  task random_phase(int n);
    int r, pid;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      pid = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 15);
      if (r < 25)
        send_cmd(MODE_ADD, pid,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 64),
                 $urandom_range(0, 63));
      else if (r < 80)
        send_cmd(MODE_CALL, pid, $urandom_range(0, 255),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                   : $urandom_range(1, sb.npages[pid] > 0 ? sb.npages[pid] : 8));
      else if (r < 96)
        send_cmd(MODE_DEL, pid, $urandom_range(0, 255), $urandom_range(0, 63));
      else
        send_cmd(MODE_NONE, pid, $urandom_range(0, 255), $urandom_range(0, 63));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: bad pids, errors, fill, self eviction, mode 3
    send_cmd(MODE_CALL, 0, 0, 1);
    send_cmd(MODE_DEL, 3, 0, 0);
    send_cmd(MODE_ADD, 1, 0, 0);
    send_cmd(MODE_ADD, 1, 101, 0);
    send_cmd(MODE_ADD, 1, 100, 63);
    send_cmd(MODE_ADD, 1, 4, 0);
    send_cmd(MODE_CALL, 1, 0, 0);
    send_cmd(MODE_CALL, 1, 26, 0);
    send_cmd(MODE_CALL, 1, 0, 25);
    send_cmd(MODE_CALL, 1, 0, 1);
    send_cmd(MODE_NONE, 15, 255, 63);
    send_cmd(MODE_ADD, 2, 100, 0);
    send_cmd(MODE_ADD, 3, 100, 0);
    send_cmd(MODE_ADD, 4, 4, 0);
    send_cmd(MODE_CALL, 2, 0, 25);
    send_cmd(MODE_DEL, 1, 0, 0);
    send_cmd(MODE_DEL, 2, 0, 0);
    send_cmd(MODE_DEL, 3, 0, 0);
    send_cmd(MODE_DEL, 4, 0, 0);

    // limit for 32 pages: a 32-page add fills RAM and a quarter of swap; the third add finds swap full
    write_limit(128);
    send_cmd(MODE_ADD, 5, 128, 0);
    send_cmd(MODE_ADD, 6, 128, 0);
    send_cmd(MODE_ADD, 7, 128, 0);
    send_cmd(MODE_CALL, 5, 0, 32);
    send_cmd(MODE_ADD, 8, 255, 0);
    random_phase(350);

    write_limit(1);
    random_phase(150);
    write_limit(255);
    stall_on = 0;
    random_phase(300);
    stall_on = 1;
    write_limit(40);
    random_phase(300);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
